/* rtl/core/bmorph_pkg.sv */
// shared constants, register codes, channel types and helper functions for the
// 3x3 binary morphology block; no dependencies
package bmorph_pkg;

    localparam int MAX_WIDTH   = 1024;
    localparam int MAX_HEIGHT  = 1024;
    localparam int KERNEL_SIZE = 3;

    localparam int WIN_BITS  = KERNEL_SIZE * KERNEL_SIZE;
    localparam int LINES     = KERNEL_SIZE - 1;
    localparam int CFG_DIM_W = 11;
    localparam int MODE_W    = 2;

    localparam int COL_W  = $clog2(MAX_WIDTH);
    localparam int FIT_WD = $clog2(MAX_WIDTH + 1);
    localparam int FIT_HT = $clog2(MAX_HEIGHT + 4);
    localparam int FIT_A  = (FIT_WD > FIT_HT) ? FIT_WD : FIT_HT;
    localparam int DIM_W  = (FIT_A > CFG_DIM_W) ? FIT_A : CFG_DIM_W;

    localparam int REG_COUNT = 4;
    localparam int REG_IDX_W = $clog2(REG_COUNT);
    localparam int PADDR_W   = REG_IDX_W + 2;
    localparam int PDATA_W   = 32;

    localparam logic [WIN_BITS-1:0]  SE_MASK_RESET = '1;
    localparam logic [CFG_DIM_W-1:0] DIM_RESET     = CFG_DIM_W'(1024);

    typedef enum logic [REG_IDX_W-1:0] {
        REG_SE_MASK,
        REG_MODE,
        REG_FRAME_WIDTH,
        REG_FRAME_HEIGHT
    } reg_idx_t;

    typedef enum logic [MODE_W-1:0] {
        MODE_DILATION,
        MODE_EROSION,
        MODE_CLOSING,
        MODE_OPENING
    } mode_t;

    typedef struct packed {
        logic op;
        logic pixel_in;
    } in_item_t;

    typedef struct packed {
        logic pixel_out;
        logic row_end;
        logic frame_end;
    } out_item_t;

    // settings seen by one morphology stage
    typedef struct packed {
        logic [DIM_W-1:0]    w;
        logic [DIM_W-1:0]    h;
        logic [WIN_BITS-1:0] mask;
        logic                erode;
    } stage_cfg_t;

    // pixel entering a stage at its next stream position
    typedef struct packed {
        logic valid;
        logic value;
        logic last;
    } stage_in_t;

    // pixel leaving a stage, positioned at the window center
    typedef struct packed {
        logic valid;
        logic in_frame;
        logic last;
        logic value;
        logic row_end;
        logic frame_end;
    } stage_res_t;

    typedef struct packed {
        logic [DIM_W-1:0] row;
        logic [COL_W-1:0] col;
    } pos_t;

    function automatic logic [DIM_W-1:0] clamp_dim(input logic [CFG_DIM_W-1:0] raw,
                                                   input logic [DIM_W-1:0]     maxv);
        logic [DIM_W-1:0] v;
        v = DIM_W'(raw);
        if (v == '0) begin
            v = DIM_W'(1);
        end else if (v > maxv) begin
            v = maxv;
        end
        return v;
    endfunction

    function automatic logic [WIN_BITS-1:0] reflect_mask(input logic [WIN_BITS-1:0] m);
        logic [WIN_BITS-1:0] r;
        for (int b = 0; b < WIN_BITS; b++) begin
            r[WIN_BITS-1-b] = m[b];
        end
        return r;
    endfunction

endpackage

/* rtl/core/binary_morphology_3x3_top.sv */
// top level of the 3x3 binary morphology block: apb registers, two stages, result register
// depends on bmorph_pkg, bmorph_stage and bmorph_ram
//
// channel   ports                         direction  transaction
// input     s_valid s_ready s_data        in         one pixel or drain item
// result    m_valid m_ready m_data        out        one result pixel with row/frame flags
// config    psel penable pwrite paddr ... in/out     one register write or read
//
// one item per cycle unless stalled: each line ram takes one read and one write per cycle
// latency: w+1 items (dilation, erosion) or 2w+2 items (closing, opening); m_valid rises
// after the item passes the a and b registers of each stage in use and the result register
// the pipeline stalls as a whole only while a result waits and m_ready is low
// reset is synchronous; line rams are not cleared, the zero frame masks stale lines
module binary_morphology_3x3_top (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    // input pixel transactions
    input  logic                                 s_valid,
    output logic                                 s_ready,
    input  bmorph_pkg::in_item_t                 s_data,
    // result transactions
    output logic                                 m_valid,
    input  logic                                 m_ready,
    output bmorph_pkg::out_item_t                m_data,
    // register port
    input  logic                                 psel,
    input  logic                                 penable,
    input  logic                                 pwrite,
    input  logic [bmorph_pkg::PADDR_W-1:0]       paddr,
    input  logic [bmorph_pkg::PDATA_W-1:0]       pwdata,
    output logic [bmorph_pkg::PDATA_W-1:0]       prdata,
    output logic                                 pready
);

    localparam int DW = bmorph_pkg::DIM_W;
    localparam int CD = bmorph_pkg::CFG_DIM_W;
    localparam int WB = bmorph_pkg::WIN_BITS;

    // configuration registers
    logic [WB-1:0]         se_mask_reg, se_mask_next;
    bmorph_pkg::mode_t     mode_reg, mode_next;
    logic [CD-1:0]         frame_width_reg, frame_width_next;
    logic [CD-1:0]         frame_height_reg, frame_height_next;

    // result register
    logic                  m_valid_reg, m_valid_next;
    bmorph_pkg::out_item_t m_data_reg, m_data_next;

    logic                  cfg_wr;
    bmorph_pkg::reg_idx_t  cfg_idx;
    logic [DW-1:0]         w_eff;
    logic [DW-1:0]         h_eff;
    logic                  en;
    logic                  two_stage;
    logic                  drop;
    logic                  q_in_frame;
    logic [DW-1:0]         last_row;
    logic [DW-1:0]         last_col;
    bmorph_pkg::pos_t      s1_pos, s2_pos;
    bmorph_pkg::stage_cfg_t s1_cfg, s2_cfg;
    bmorph_pkg::stage_in_t  s1_in, s2_in;
    bmorph_pkg::stage_res_t s1_res, s2_res, cand;

    // register port: no wait states
    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite && pready;
    assign cfg_idx = bmorph_pkg::reg_idx_t'(paddr[bmorph_pkg::PADDR_W-1:2]);

    always_comb begin
        se_mask_next      = se_mask_reg;
        mode_next         = mode_reg;
        frame_width_next  = frame_width_reg;
        frame_height_next = frame_height_reg;
        if (cfg_wr) begin
            case (cfg_idx)
                bmorph_pkg::REG_SE_MASK:      se_mask_next      = pwdata[WB-1:0];
                bmorph_pkg::REG_MODE:         mode_next         =
                    bmorph_pkg::mode_t'(pwdata[bmorph_pkg::MODE_W-1:0]);
                bmorph_pkg::REG_FRAME_WIDTH:  frame_width_next  = pwdata[CD-1:0];
                bmorph_pkg::REG_FRAME_HEIGHT: frame_height_next = pwdata[CD-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (cfg_idx)
            bmorph_pkg::REG_SE_MASK:      prdata = bmorph_pkg::PDATA_W'(se_mask_reg);
            bmorph_pkg::REG_MODE:         prdata = bmorph_pkg::PDATA_W'(mode_reg);
            bmorph_pkg::REG_FRAME_WIDTH:  prdata = bmorph_pkg::PDATA_W'(frame_width_reg);
            bmorph_pkg::REG_FRAME_HEIGHT: prdata = bmorph_pkg::PDATA_W'(frame_height_reg);
            default:                      prdata = '0;
        endcase
    end

    // out-of-range sizes saturate
    assign w_eff = bmorph_pkg::clamp_dim(frame_width_reg, DW'(bmorph_pkg::MAX_WIDTH));
    assign h_eff = bmorph_pkg::clamp_dim(frame_height_reg, DW'(bmorph_pkg::MAX_HEIGHT));

    // whole pipeline moves when the result register is free or being emptied
    assign en      = !m_valid_reg || m_ready;
    assign s_ready = en;

    assign two_stage = (mode_reg == bmorph_pkg::MODE_CLOSING) ||
                       (mode_reg == bmorph_pkg::MODE_OPENING);

    // drain before the frame is complete is swallowed
    assign q_in_frame = (s1_pos.row < h_eff);
    assign drop       = s_data.op && q_in_frame;

    // input position of the item that produces the final pixel of the frame:
    // n+w for one stage, n+2w+1 for two stages
    always_comb begin
        if (!two_stage) begin
            last_row = h_eff + DW'(1);
            last_col = '0;
        end else if (w_eff == DW'(1)) begin
            last_row = h_eff + DW'(3);
            last_col = '0;
        end else begin
            last_row = h_eff + DW'(2);
            last_col = DW'(1);
        end
    end

    always_comb begin
        s1_in.valid = s_valid && !drop;
        s1_in.value = !s_data.op && q_in_frame && s_data.pixel_in;
        s1_in.last  = (s1_pos.row == last_row) && (DW'(s1_pos.col) == last_col);
    end

    always_comb begin
        s1_cfg.w     = w_eff;
        s1_cfg.h     = h_eff;
        s1_cfg.mask  = se_mask_reg;
        s1_cfg.erode = (mode_reg == bmorph_pkg::MODE_EROSION) ||
                       (mode_reg == bmorph_pkg::MODE_OPENING);
        s2_cfg       = s1_cfg;
        s2_cfg.erode = (mode_reg == bmorph_pkg::MODE_CLOSING);
    end

    bmorph_stage u_stage1 (
        .aclk    (aclk),
        .aresetn (aresetn),
        .en      (en),
        .cfg     (s1_cfg),
        .in_item (s1_in),
        .res     (s1_res),
        .pos     (s1_pos)
    );

    // second stage only sees traffic for closing and opening
    always_comb begin
        s2_in.valid = s1_res.valid && two_stage;
        s2_in.value = s1_res.value;
        s2_in.last  = s1_res.last;
    end

    bmorph_stage u_stage2 (
        .aclk    (aclk),
        .aresetn (aresetn),
        .en      (en),
        .cfg     (s2_cfg),
        .in_item (s2_in),
        .res     (s2_res),
        .pos     (s2_pos)
    );

    assign cand = two_stage ? s2_res : s1_res;

    always_comb begin
        m_valid_next = m_valid_reg;
        m_data_next  = m_data_reg;
        if (en) begin
            m_valid_next          = cand.valid && cand.in_frame;
            m_data_next.pixel_out = cand.value;
            m_data_next.row_end   = cand.row_end;
            m_data_next.frame_end = cand.frame_end;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            se_mask_reg      <= bmorph_pkg::SE_MASK_RESET;
            mode_reg         <= bmorph_pkg::MODE_DILATION;
            frame_width_reg  <= bmorph_pkg::DIM_RESET;
            frame_height_reg <= bmorph_pkg::DIM_RESET;
            m_valid_reg      <= 1'b0;
        end else begin
            se_mask_reg      <= se_mask_next;
            mode_reg         <= mode_next;
            frame_width_reg  <= frame_width_next;
            frame_height_reg <= frame_height_next;
            m_valid_reg      <= m_valid_next;
        end
        m_data_reg <= m_data_next;
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    // a swallowed drain leaves the input position alone
    a_drop_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready && drop) |=> (s1_pos == $past(s1_pos)))
        else $error("input position moved on a swallowed drain");

    // the item that finishes the frame restarts the input position
    a_last_restarts: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready && s1_in.valid && s1_in.last)
            |=> (s1_pos.row == '0 && s1_pos.col == '0))
        else $error("input position not restarted after the frame's last item");

    // the last pixel of a frame also closes its row
    a_frame_end_row: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_data.frame_end) |-> m_data.row_end)
        else $error("frame end without row end");

    // stage two rests at its frame start while only stage one is in use
    a_s2_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        (!two_stage) |-> (s2_pos == '0))
        else $error("second stage position moved in a single stage mode");

endmodule

/* rtl/core/bmorph_ram.sv */
// generic single-write, single-read ram with registered read data (read-first)
// no dependencies
module bmorph_ram #(
    parameter int WIDTH = 1,
    parameter int DEPTH = 2,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             aclk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic             rd_en,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

/* rtl/core/bmorph_stage.sv */
// one line-buffered 3x3 morphology stage: position counter, line ram, window, operator
// depends on bmorph_pkg and bmorph_ram
module bmorph_stage (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   en,
    input  bmorph_pkg::stage_cfg_t cfg,
    input  bmorph_pkg::stage_in_t  in_item,
    output bmorph_pkg::stage_res_t res,
    output bmorph_pkg::pos_t       pos
);

    localparam int DW = bmorph_pkg::DIM_W;
    localparam int CW = bmorph_pkg::COL_W;
    localparam int LW = bmorph_pkg::LINES;
    localparam int KS = bmorph_pkg::KERNEL_SIZE;
    localparam int WB = bmorph_pkg::WIN_BITS;
    localparam logic signed [DW:0] ONE_S = (DW+1)'(1);
    localparam logic signed [DW:0] TWO_S = (DW+1)'(2);

    typedef struct packed {
        logic                 valid;
        logic                 value;
        logic                 last;
        logic [CW-1:0]        addr;
        logic signed [DW:0]   row_m;
        logic [CW-1:0]        col_m;
        logic                 byp;
        logic [LW-1:0]        byp_data;
    } fetch_t;

    bmorph_pkg::pos_t       pos_reg, pos_next;
    fetch_t                 a_reg, a_next;
    bmorph_pkg::stage_res_t b_reg, b_next;
    logic [WB-1:0]          win_reg, win_next;

    logic                   in_fire;
    logic [DW-1:0]          w_m1;
    logic [CW-1:0]          w_last_col;
    logic signed [DW:0]     h_s;
    logic signed [DW:0]     row_m;
    logic [CW-1:0]          col_m;
    logic [LW-1:0]          ram_rd;
    logic [LW-1:0]          line_rd;
    logic [LW-1:0]          wr_data;
    logic                   wr_en;
    logic [KS-1:0]          new_col;
    logic [KS-1:0]          row_ok;
    logic [KS-1:0]          col_ok;
    logic [WB-1:0]          win_vis;
    logic                   op_out;
    logic                   in_frame;

    assign in_fire    = in_item.valid && en;
    assign w_m1       = cfg.w - 1'b1;
    assign w_last_col = w_m1[CW-1:0];
    assign h_s        = $signed({1'b0, cfg.h});

    // center of the window that this pixel completes: one row and one pixel back
    always_comb begin
        if (pos_reg.col == '0) begin
            row_m = $signed({1'b0, pos_reg.row}) - TWO_S;
            col_m = w_last_col;
        end else begin
            row_m = $signed({1'b0, pos_reg.row}) - ONE_S;
            col_m = pos_reg.col - 1'b1;
        end
    end

    always_comb begin
        pos_next = pos_reg;
        if (in_fire) begin
            if (in_item.last) begin
                pos_next = '0;
            end else if (pos_reg.col == w_last_col) begin
                pos_next.col = '0;
                pos_next.row = pos_reg.row + 1'b1;
            end else begin
                pos_next.col = pos_reg.col + 1'b1;
            end
        end
    end

    // line ram: {two rows up, one row up} per column
    assign line_rd = a_reg.byp ? a_reg.byp_data : ram_rd;
    assign wr_data = {line_rd[0], a_reg.value};
    assign wr_en   = a_reg.valid && en;

    bmorph_ram #(
        .WIDTH (LW),
        .DEPTH (bmorph_pkg::MAX_WIDTH)
    ) u_lines (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (a_reg.addr),
        .wr_data (wr_data),
        .rd_en   (in_fire),
        .rd_addr (pos_reg.col),
        .rd_data (ram_rd)
    );

    always_comb begin
        a_next = a_reg;
        if (en) begin
            a_next.valid    = in_item.valid;
            a_next.value    = in_item.value;
            a_next.last     = in_item.last;
            a_next.addr     = pos_reg.col;
            a_next.row_m    = row_m;
            a_next.col_m    = col_m;
            // same column written on this edge: forward the write data
            a_next.byp      = a_reg.valid && (a_reg.addr == pos_reg.col);
            a_next.byp_data = wr_data;
        end
    end

    // window shift: column k = 2 is the newest, row s = 2 the current line
    always_comb begin
        new_col = {a_reg.value, line_rd[0], line_rd[1]};
        win_next = win_reg;
        if (wr_en) begin
            for (int s = 0; s < KS; s++) begin
                for (int k = 0; k < KS - 1; k++) begin
                    win_next[s*KS+k] = win_reg[s*KS+k+1];
                end
                win_next[s*KS+KS-1] = new_col[s];
            end
        end
    end

    // zero frame around the image
    always_comb begin
        row_ok    = '1;
        col_ok    = '1;
        row_ok[0] = (a_reg.row_m >= ONE_S);
        row_ok[2] = (a_reg.row_m < (h_s - ONE_S));
        col_ok[0] = (a_reg.col_m != '0);
        col_ok[2] = (a_reg.col_m != w_last_col);
        for (int s = 0; s < KS; s++) begin
            for (int k = 0; k < KS; k++) begin
                win_vis[s*KS+k] = win_next[s*KS+k] && row_ok[s] && col_ok[k];
            end
        end
    end

    assign op_out   = cfg.erode ? ((win_vis & cfg.mask) == cfg.mask)
                                : (|(win_vis & bmorph_pkg::reflect_mask(cfg.mask)));
    assign in_frame = !a_reg.row_m[DW] && (a_reg.row_m < h_s);

    always_comb begin
        b_next = b_reg;
        if (en) begin
            b_next.valid     = a_reg.valid && !a_reg.row_m[DW];
            b_next.in_frame  = in_frame;
            b_next.last      = a_reg.last;
            b_next.value     = in_frame && op_out;
            b_next.row_end   = (a_reg.col_m == w_last_col);
            b_next.frame_end = (a_reg.col_m == w_last_col) && (a_reg.row_m == (h_s - ONE_S));
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg <= '0;
            a_reg   <= '0;
            b_reg   <= '0;
        end else begin
            pos_reg <= pos_next;
            a_reg   <= a_next;
            b_reg   <= b_next;
        end
        win_reg <= win_next;
    end

    assign res = b_reg;
    assign pos = pos_reg;

endmodule
